// File: sv/cmim_pkg.sv
// Shared types, widths and helpers for the column-major index mapper.
package cmim_pkg;

    localparam int NFIELD       = 4;   // coordinate fields on the ports
    localparam int MAX_DIMS_DEF = 4;
    localparam int KEY_BITS_DEF = 60;
    localparam int COORD_W      = 15;
    localparam int KEY_FIELD_W  = 60;
    localparam int STEP_W       = 61;
    localparam int WORK_W       = 64;  // signed working width for move
    localparam int CNT_W        = 6;   // bit counter, up to WORK_W-1
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    typedef enum logic [1:0] {
        OP_LIN  = 2'd0,
        OP_UNL  = 2'd1,
        OP_MOVE = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_DIM_COUNT = 3'd0,
        REG_EXTENT0   = 3'd1,
        REG_EXTENT1   = 3'd2,
        REG_EXTENT2   = 3'd3,
        REG_EXTENT3   = 3'd4
    } t_reg;

    // A zero extent behaves as one.
    function automatic logic [COORD_W-1:0] ext_eff(input logic [COORD_W-1:0] e);
        ext_eff = (e == '0) ? COORD_W'(1) : e;
    endfunction

endpackage

// File: sv/column_major_index_mapper_top.sv
// Column-major index mapper: linearize, unlinearize and move, bit-serial datapath.
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  -------------------------------------
//  input     in         i_in_valid / o_in_stall      i_operation, i_in_coord0..3, i_in_key,
//                                                     i_step_diff
//  output    out        o_out_valid / i_out_stall    o_out_key, o_out_coord0..3,
//                                                     o_range_error
//  config    in         APB (psel, penable, pwrite)  paddr, pwdata, prdata, pready
//
// One transaction at a time. Linearize: per dimension, a 15-step shift-add multiply
// plus the coordinate add. Unlinearize: per dimension, a restoring divide over the
// KEY_BITS key bits. Move: per dimension, a range check, a 64-step divide and a carry
// add; a dimension whose value is already in range ends the carry chain.
// Acceptance and the output load each have their own state. Reset (synchronous,
// active low) clears the sequencer, output valid and the config registers
// (dim_count 1, extents 1). A stalled output holds the finished result; the next
// transaction is taken meanwhile and waits in the done state until the slot frees.
module column_major_index_mapper_top
    import cmim_pkg::*;
#(
    parameter int MAX_DIMS = MAX_DIMS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_operation,
    input  logic [COORD_W-1:0]        i_in_coord0,
    input  logic [COORD_W-1:0]        i_in_coord1,
    input  logic [COORD_W-1:0]        i_in_coord2,
    input  logic [COORD_W-1:0]        i_in_coord3,
    input  logic [KEY_FIELD_W-1:0]    i_in_key,
    input  logic signed [STEP_W-1:0]  i_step_diff,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [KEY_FIELD_W-1:0]    o_out_key,
    output logic [COORD_W-1:0]        o_out_coord0,
    output logic [COORD_W-1:0]        o_out_coord1,
    output logic [COORD_W-1:0]        o_out_coord2,
    output logic [COORD_W-1:0]        o_out_coord3,
    output logic                      o_range_error,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    // dimensions actually backed by storage
    localparam int NDIM     = (MAX_DIMS < NFIELD) ? MAX_DIMS : NFIELD;
    localparam int DIDX_W   = (NDIM > 1) ? $clog2(NDIM) : 1;
    localparam int UL_SHIFT = WORK_W - KEY_BITS;
    localparam logic [CNT_W-1:0] UL_LAST   = CNT_W'(KEY_BITS - 1);
    localparam logic [CNT_W-1:0] MV_LAST   = CNT_W'(WORK_W - 1);
    localparam logic [CNT_W-1:0] MUL_FIRST = CNT_W'(COORD_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MUL_ADD,
        ST_DIV,
        ST_DIV_END,
        ST_MV_CHECK,
        ST_DONE
    } t_state;

    // ---------------- configuration registers ----------------
    logic [2:0]         r_dim_count;
    logic [COORD_W-1:0] r_ext [NFIELD];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= 3'd1;
            for (int i = 0; i < NFIELD; i++) begin
                r_ext[i] <= COORD_W'(1);
            end
        end else if (psel && penable && pwrite) begin
            unique case (t_reg'(paddr[4:2]))
                REG_DIM_COUNT: r_dim_count <= pwdata[2:0];
                REG_EXTENT0:   r_ext[0]    <= pwdata[COORD_W-1:0];
                REG_EXTENT1:   r_ext[1]    <= pwdata[COORD_W-1:0];
                REG_EXTENT2:   r_ext[2]    <= pwdata[COORD_W-1:0];
                REG_EXTENT3:   r_ext[3]    <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[4:2]))
            REG_DIM_COUNT: prdata = DATA_W'(r_dim_count);
            REG_EXTENT0:   prdata = DATA_W'(r_ext[0]);
            REG_EXTENT1:   prdata = DATA_W'(r_ext[1]);
            REG_EXTENT2:   prdata = DATA_W'(r_ext[2]);
            REG_EXTENT3:   prdata = DATA_W'(r_ext[3]);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------- datapath registers ----------------
    t_state               r_state;
    t_op                  r_op;
    logic [DIDX_W-1:0]    r_k;        // dimension being worked on
    logic [DIDX_W-1:0]    r_last;     // top dimension in use
    logic [CNT_W-1:0]     r_cnt;      // bit counter
    logic [WORK_W-1:0]    r_num;      // dividend/quotient or product shift register
    logic [COORD_W-1:0]   r_rem;      // partial remainder
    logic                 r_neg;      // dividend sign for move
    logic [WORK_W-1:0]    r_cur;      // signed value carried along in move
    logic [KEY_BITS-1:0]  r_acc;      // Horner accumulator
    logic [COORD_W-1:0]   r_c [NDIM]; // working coordinates
    logic                 r_err;

    logic                    r_ov;
    logic [KEY_FIELD_W-1:0]  r_okey;
    logic [COORD_W-1:0]      r_oc [NFIELD];
    logic                    r_oerr;

    // ---------------- combinational helpers ----------------
    logic [COORD_W-1:0]   w_in_c [NFIELD];
    logic [COORD_W-1:0]   w_ext  [NDIM];
    logic [COORD_W-1:0]   w_c4   [NFIELD];
    logic [DIDX_W-1:0]    w_last;
    logic                 w_err;
    t_op                  w_op;
    logic [WORK_W-1:0]    w_in_key64;
    logic [KEY_BITS-1:0]  w_key_in;
    logic [COORD_W-1:0]   w_e;
    logic [COORD_W:0]     w_t;
    logic [COORD_W:0]     w_t_sub;
    logic                 w_ge;
    logic [COORD_W-1:0]   w_rem_step;
    logic [WORK_W-1:0]    w_prod;
    logic                 w_inrange;
    logic [COORD_W-1:0]   w_rmod;
    logic [DIDX_W-1:0]    w_kn;
    logic [COORD_W-1:0]   w_cnext;
    logic [WORK_W-1:0]    w_carry;
    logic [WORK_W-1:0]    w_mag;
    logic [CNT_W-1:0]     w_div_last;
    logic [WORK_W-1:0]    w_acc64;

    assign w_in_c[0] = i_in_coord0;
    assign w_in_c[1] = i_in_coord1;
    assign w_in_c[2] = i_in_coord2;
    assign w_in_c[3] = i_in_coord3;

    for (genvar g = 0; g < NFIELD; g++) begin : g_c4
        if (g < NDIM) begin : g_used
            assign w_c4[g] = r_c[g];
        end else begin : g_unused
            assign w_c4[g] = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < NDIM; i++) begin
            w_ext[i] = ext_eff(r_ext[i]);
        end
    end

    // dim_count 0 acts as 1; anything above the stored dimensions is clamped
    always_comb begin
        if (r_dim_count == 3'd0) begin
            w_last = '0;
        end else if (r_dim_count >= 3'(NDIM)) begin
            w_last = DIDX_W'(NDIM - 1);
        end else begin
            w_last = DIDX_W'(r_dim_count - 3'd1);
        end
    end

    assign w_op = t_op'(i_operation);

    always_comb begin
        w_err = 1'b0;
        if (w_op == OP_LIN || w_op == OP_MOVE) begin
            for (int i = 0; i < NDIM; i++) begin
                if (DIDX_W'(i) <= w_last && w_in_c[i] >= w_ext[i]) begin
                    w_err = 1'b1;
                end
            end
        end
    end

    assign w_in_key64 = WORK_W'(i_in_key);
    assign w_key_in   = w_in_key64[KEY_BITS-1:0];
    assign w_acc64    = WORK_W'(r_acc);

    assign w_e = w_ext[r_k];

    // restoring divide step: one dividend bit enters the remainder per cycle
    assign w_t        = {r_rem, r_num[WORK_W-1]};
    assign w_ge       = (w_t >= {1'b0, w_e});
    assign w_t_sub    = w_t - {1'b0, w_e};
    assign w_rem_step = w_ge ? w_t_sub[COORD_W-1:0] : w_t[COORD_W-1:0];
    assign w_div_last = (r_op == OP_UNL) ? UL_LAST : MV_LAST;

    // shift-add multiply, extent bits MSB first
    assign w_prod = {r_num[WORK_W-2:0], 1'b0} + (w_e[r_cnt[3:0]] ? w_acc64 : '0);

    // move: floor division result from magnitude quotient and remainder
    assign w_inrange = !r_cur[WORK_W-1] && (r_cur < WORK_W'(w_e));
    assign w_rmod    = (r_neg && r_rem != '0) ? (w_e - r_rem) : r_rem;
    assign w_kn      = r_k + DIDX_W'(1);
    assign w_cnext   = (r_k == r_last) ? '0 : r_c[w_kn];
    // negative: quotient is ~q when a remainder is left, -q otherwise
    assign w_carry   = WORK_W'(w_cnext) + (r_neg ? ~r_num : r_num)
                     + WORK_W'(r_neg && r_rem == '0);
    assign w_mag     = r_cur[WORK_W-1] ? (~r_cur + WORK_W'(1)) : r_cur;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // the done state reloads the output slot itself
            if (r_ov && !i_out_stall && r_state != ST_DONE) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op   <= w_op;
                        r_last <= w_last;
                        r_err  <= w_err;
                        r_acc  <= '0;
                        r_rem  <= '0;
                        r_neg  <= 1'b0;
                        r_cur  <= WORK_W'(w_in_c[0]) + WORK_W'(i_step_diff);
                        for (int i = 0; i < NDIM; i++) begin
                            r_c[i] <= ((w_op == OP_LIN || w_op == OP_MOVE)
                                       && DIDX_W'(i) <= w_last) ? w_in_c[i] : '0;
                        end
                        unique case (w_op)
                            OP_LIN: begin
                                r_k     <= w_last;
                                r_num   <= '0;
                                r_cnt   <= MUL_FIRST;
                                r_state <= ST_MUL;
                            end
                            OP_UNL: begin
                                r_k     <= '0;
                                r_num   <= WORK_W'(w_key_in) << UL_SHIFT;
                                r_cnt   <= '0;
                                r_state <= ST_DIV;
                            end
                            OP_MOVE: begin
                                r_k     <= '0;
                                r_state <= ST_MV_CHECK;
                            end
                            default: begin
                                r_k     <= '0;
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    r_num <= w_prod;
                    if (r_cnt == '0) begin
                        r_state <= ST_MUL_ADD;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                ST_MUL_ADD: begin
                    r_acc <= r_num[KEY_BITS-1:0] + KEY_BITS'(r_c[r_k]);
                    if (r_k == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_k     <= r_k - DIDX_W'(1);
                        r_num   <= '0;
                        r_cnt   <= MUL_FIRST;
                        r_state <= ST_MUL;
                    end
                end
                ST_DIV: begin
                    r_num <= {r_num[WORK_W-2:0], w_ge};
                    r_rem <= w_rem_step;
                    if (r_cnt == w_div_last) begin
                        r_state <= ST_DIV_END;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_DIV_END: begin
                    if (r_op == OP_UNL) begin
                        r_c[r_k] <= r_rem;
                        if (r_k == r_last) begin
                            r_state <= ST_DONE;
                        end else begin
                            // quotient sits in the low KEY_BITS; realign for next pass
                            r_k     <= w_kn;
                            r_num   <= r_num << UL_SHIFT;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_DIV;
                        end
                    end else begin
                        r_c[r_k] <= w_rmod;
                        if (r_k == r_last) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_cur   <= w_carry;
                            r_k     <= w_kn;
                            r_state <= ST_MV_CHECK;
                        end
                    end
                end
                ST_MV_CHECK: begin
                    if (r_k != r_last && w_inrange) begin
                        // no carry: lower dims stop, only the top wrap remains
                        r_c[r_k] <= r_cur[COORD_W-1:0];
                        r_k      <= r_last;
                        r_cur    <= WORK_W'(r_c[r_last]);
                    end else begin
                        r_neg   <= r_cur[WORK_W-1];
                        r_num   <= w_mag;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DONE: begin
                    if (!r_ov || !i_out_stall) begin
                        r_okey <= (r_op == OP_LIN) ? w_acc64[KEY_FIELD_W-1:0] : '0;
                        for (int i = 0; i < NFIELD; i++) begin
                            r_oc[i] <= (r_op == OP_LIN) ? '0 : w_c4[i];
                        end
                        r_oerr  <= r_err;
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_ov;
    assign o_out_key     = r_okey;
    assign o_out_coord0  = r_oc[0];
    assign o_out_coord1  = r_oc[1];
    assign o_out_coord2  = r_oc[2];
    assign o_out_coord3  = r_oc[3];
    assign o_range_error = r_oerr;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the column-major index mapper: directed corners, then random traffic.
module testbench;
    import cmim_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;  // covers ~550 transactions with a wide margin
    localparam int DRAIN_CYCLES = 300;        // above the worst-case latency of one transaction
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        t_op                              op;
        logic [NFIELD-1:0][COORD_W-1:0]   coord;
        logic [KEY_FIELD_W-1:0]           key;
        logic [STEP_W-1:0]                step;
    } t_map_req;

    typedef struct packed {
        logic [KEY_FIELD_W-1:0]           key;
        logic [NFIELD-1:0][COORD_W-1:0]   coord;
        logic                             range_err;
    } t_map_rsp;

    // DUT ports; every input has a known value from time zero
    logic                      i_clk;
    logic                      i_rst_n      = 1'b0;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_operation  = '0;
    logic [COORD_W-1:0]        i_in_coord0  = '0;
    logic [COORD_W-1:0]        i_in_coord1  = '0;
    logic [COORD_W-1:0]        i_in_coord2  = '0;
    logic [COORD_W-1:0]        i_in_coord3  = '0;
    logic [KEY_FIELD_W-1:0]    i_in_key     = '0;
    logic signed [STEP_W-1:0]  i_step_diff  = '0;
    logic                      o_out_valid;
    logic                      i_out_stall  = 1'b0;
    logic [KEY_FIELD_W-1:0]    o_out_key;
    logic [COORD_W-1:0]        o_out_coord0;
    logic [COORD_W-1:0]        o_out_coord1;
    logic [COORD_W-1:0]        o_out_coord2;
    logic [COORD_W-1:0]        o_out_coord3;
    logic                      o_range_error;
    logic                      psel         = 1'b0;
    logic                      penable      = 1'b0;
    logic                      pwrite       = 1'b0;
    logic [ADDR_W-1:0]         paddr        = '0;
    logic [DATA_W-1:0]         pwdata       = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    // mirror of the configuration registers
    logic [2:0]                dims_cfg;
    logic [COORD_W-1:0]        extent_cfg [NFIELD];

    t_map_rsp                  pending_results [$];
    int                        fail_count    = 0;
    int                        cycle_count   = 0;
    int                        send_idle_pct = 0;
    int                        stall_pct     = 0;
    int                        hold_off_len  = 0;  // one long output hold-off, set once
    int                        held          = 0;

    column_major_index_mapper_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_in_coord0   (i_in_coord0),
        .i_in_coord1   (i_in_coord1),
        .i_in_coord2   (i_in_coord2),
        .i_in_coord3   (i_in_coord3),
        .i_in_key      (i_in_key),
        .i_step_diff   (i_step_diff),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_key     (o_out_key),
        .o_out_coord0  (o_out_coord0),
        .o_out_coord1  (o_out_coord1),
        .o_out_coord2  (o_out_coord2),
        .o_out_coord3  (o_out_coord3),
        .o_range_error (o_range_error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    always @(posedge i_clk) begin
        if (held < hold_off_len) begin
            i_out_stall <= 1'b1;
            held <= held + 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------- prediction

    // zero extent acts as one
    function automatic logic [63:0] dim_len(input int k);
        return (extent_cfg[k] == '0) ? 64'd1 : 64'(extent_cfg[k]);
    endfunction

    // dimension count clamped to 1..NFIELD
    function automatic int dims_in_use();
        if (dims_cfg == '0) return 1;
        if (int'(dims_cfg) > NFIELD) return NFIELD;
        return int'(dims_cfg);
    endfunction

    function automatic t_map_rsp map_index(input t_map_req rq);
        t_map_rsp    rs;
        int          n;
        longint      c [NFIELD];
        longint      e;
        longint      r;
        logic [63:0] acc;
        logic [63:0] len;
        rs = '0;
        n  = dims_in_use();
        for (int k = 0; k < NFIELD; k++) c[k] = longint'(64'(rq.coord[k]));

        // only dimensions in use can flag
        if (rq.op == OP_LIN || rq.op == OP_MOVE)
            for (int k = 0; k < n; k++)
                if (c[k] >= longint'(dim_len(k))) rs.range_err = 1'b1;

        case (rq.op)
            OP_LIN: begin
                acc = '0;
                for (int k = n - 1; k >= 0; k--) acc = acc * dim_len(k) + 64'(rq.coord[k]);
                rs.key = acc[KEY_FIELD_W-1:0];
            end
            OP_UNL: begin
                acc = 64'(rq.key);
                for (int k = 0; k < n; k++) begin
                    len         = dim_len(k);
                    rs.coord[k] = COORD_W'(acc % len);
                    acc         = acc / len;
                end
            end
            OP_MOVE: begin
                c[0] += longint'({{(64-STEP_W){rq.step[STEP_W-1]}}, rq.step});
                // floor-divide carry upward; stops at the first in-range dimension
                for (int k = 0; k < n - 1; k++) begin
                    e = longint'(dim_len(k));
                    if (c[k] >= 0 && c[k] < e) break;
                    c[k+1] += c[k] / e;
                    r = c[k] % e;
                    if (r < 0) begin
                        r += e;
                        c[k+1] -= 1;
                    end
                    c[k] = r;
                end
                // top dimension wraps
                e = longint'(dim_len(n - 1));
                r = c[n-1] % e;
                if (r < 0) r += e;
                c[n-1] = r;
                for (int k = 0; k < n; k++) rs.coord[k] = c[k][COORD_W-1:0];
            end
            default: ;
        endcase
        return rs;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("mismatch on %s at cycle %0d: expected 0x%0h, got 0x%0h",
                         name, cycle_count, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_map_rsp want;
        t_map_rsp got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.key       = o_out_key;
            got.coord     = {o_out_coord3, o_out_coord2, o_out_coord1, o_out_coord0};
            got.range_err = o_range_error;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("result with nothing pending at cycle %0d: key 0x%0h",
                             cycle_count, got.key);
            end else begin
                want = pending_results.pop_front();
                compare_field("key", 64'(want.key), 64'(got.key));
                for (int k = 0; k < NFIELD; k++)
                    compare_field($sformatf("coord%0d", k), 64'(want.coord[k]),
                                  64'(got.coord[k]));
                compare_field("range_error", 64'(want.range_err), 64'(got.range_err));
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // One input transaction; expectation is queued at the accepting edge.
    task automatic send_item(input t_map_req rq);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_operation <= rq.op;
        i_in_coord0 <= rq.coord[0];
        i_in_coord1 <= rq.coord[1];
        i_in_coord2 <= rq.coord[2];
        i_in_coord3 <= rq.coord[3];
        i_in_key    <= rq.key;
        i_step_diff <= rq.step;
        i_in_valid  <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(map_index(rq));
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // APB write, setup then access, then back to idle; unused upper data bits carry noise
    task automatic write_reg(input t_reg idx, input logic [COORD_W-1:0] val);
        logic [DATA_W-1:0] noise;
        noise   = DATA_W'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (idx == REG_DIM_COUNT) ? {noise[DATA_W-1:3], val[2:0]}
                                          : {noise[DATA_W-1:COORD_W], val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DIM_COUNT) dims_cfg = val[2:0];
        else extent_cfg[int'(idx) - 1] = val;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [2:0] dims, input logic [COORD_W-1:0] e0,
                              input logic [COORD_W-1:0] e1, input logic [COORD_W-1:0] e2,
                              input logic [COORD_W-1:0] e3);
        write_reg(REG_DIM_COUNT, COORD_W'(dims));
        write_reg(REG_EXTENT0, e0);
        write_reg(REG_EXTENT1, e1);
        write_reg(REG_EXTENT2, e2);
        write_reg(REG_EXTENT3, e3);
    endtask

    // ---------------------------------------------------------------- random stimulus

    function automatic logic [COORD_W-1:0] pick_extent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COORD_W'(1);
            2, 3, 4: return COORD_W'($urandom_range(2, 9));
            5, 6:    return COORD_W'($urandom_range(10, 400));
            7:       return '1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] pick_dims();
        case ($urandom_range(0, 9))
            0:       return 3'd0;
            1:       return 3'($urandom_range(5, 7));
            default: return 3'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic random_config();
        set_config(pick_dims(), pick_extent(), pick_extent(), pick_extent(), pick_extent());
    endtask

    // Mostly in-range coordinates and keys near the total size; some raw noise.
    function automatic t_map_req random_item();
        t_map_req    rq;
        logic [63:0] total;
        logic [63:0] r64;
        longint      span;
        longint      d;
        bit          noisy;
        total = 64'd1;
        for (int k = 0; k < dims_in_use(); k++) total = total * dim_len(k);
        rq.op = ($urandom_range(0, 19) == 0) ? OP_NONE : t_op'($urandom_range(0, 2));

        noisy = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < NFIELD; k++) begin
            if (noisy && $urandom_range(0, 1) == 1)
                rq.coord[k] = ($urandom_range(0, 1) == 1) ? COORD_W'($urandom)
                                                          : COORD_W'(dim_len(k));
            else
                rq.coord[k] = COORD_W'($urandom_range(0, int'(dim_len(k)) - 1));
        end

        r64 = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0, 1:    rq.key = KEY_FIELD_W'(r64 % total);
            2:       rq.key = KEY_FIELD_W'(total * $urandom_range(1, 3) + r64 % 4);
            default: rq.key = r64[KEY_FIELD_W-1:0];
        endcase

        r64 = {$urandom, $urandom};
        case ($urandom_range(0, 2))
            0: begin
                span = longint'(dim_len(0)) * 3;
                d    = longint'($urandom_range(0, int'(2 * span))) - span;
            end
            1:       d = longint'(r64 % (2 * total)) - longint'(total);
            default: d = longint'(r64);
        endcase
        rq.step = d[STEP_W-1:0];
        return rq;
    endfunction

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // ---------------------------------------------------------------- tests

    // Reset values: one dimension of length one.
    task automatic test_reset_state();
        t_map_req rq;
        rq = '0;
        rq.op = OP_LIN;
        send_item(rq);
        rq.coord = '1;            // coord0 out of range, unused ones ignored
        send_item(rq);
        rq.op  = OP_UNL;
        rq.key = '1;
        send_item(rq);
        rq.op    = OP_MOVE;
        rq.coord = '0;
        rq.step  = {1'b0, {(STEP_W-1){1'b1}}};
        send_item(rq);
        rq.step = {1'b1, {(STEP_W-1){1'b0}}};
        send_item(rq);
        rq.op    = OP_NONE;
        rq.coord = '1;
        rq.key   = '1;
        rq.step  = '1;
        send_item(rq);
        wait_results_drained();
    endtask

    // Dimension count 0 and above four, zero extents.
    task automatic test_dim_clamp();
        t_map_req rq;
        set_config(3'd0, 15'd0, 15'd5, 15'd5, 15'd5);
        rq          = '0;
        rq.op       = OP_LIN;
        rq.coord[1] = 15'd3;
        send_item(rq);
        rq.op  = OP_UNL;
        rq.key = 60'd77;
        send_item(rq);
        wait_results_drained();

        set_config(3'd7, 15'd3, 15'd0, 15'd4, 15'd2);
        rq       = '0;
        rq.op    = OP_LIN;
        rq.coord = {15'd1, 15'd3, 15'd0, 15'd2};
        send_item(rq);
        rq.coord[1] = 15'd1;      // against a zero extent
        send_item(rq);
        rq.op  = OP_UNL;
        rq.key = 60'd100;         // beyond the total of 24, wraps
        send_item(rq);
        rq.op    = OP_MOVE;
        rq.coord = {15'd1, 15'd3, 15'd0, 15'd2};
        rq.step  = -61'sd50;
        send_item(rq);
        wait_results_drained();
    endtask

    // All four dimensions at full length.
    task automatic test_extremes();
        t_map_req rq;
        set_config(3'd4, '1, '1, '1, '1);
        rq       = '0;
        rq.op    = OP_LIN;
        rq.coord = {4{15'h7FFE}};  // largest key
        send_item(rq);
        rq.coord = '1;             // every coordinate out of range
        send_item(rq);
        rq.op  = OP_UNL;
        rq.key = '1;
        send_item(rq);
        rq.op    = OP_MOVE;
        rq.coord = '0;
        rq.step  = '1;             // minus one: borrow through all, top wraps
        send_item(rq);
        rq.coord = {4{15'h7FFE}};
        rq.step  = 61'd1;          // carry ripples through all
        send_item(rq);
        rq.step = {1'b0, {(STEP_W-1){1'b1}}};
        send_item(rq);
        rq.coord = '0;
        rq.step  = {1'b1, {(STEP_W-1){1'b0}}};
        send_item(rq);
        wait_results_drained();
    endtask

    // Random configurations under each idling mix.
    task automatic test_random_traffic();
        int mode_send [4] = '{0, 64, 0, 11};
        int mode_recv [4] = '{0, 0, 64, 11};
        for (int m = 0; m < 4; m++) begin
            set_idling(mode_send[m], mode_recv[m]);
            for (int p = 0; p < 4; p++) begin
                random_config();
                repeat (28) send_item(random_item());
                wait_results_drained();
            end
        end
        set_idling(0, 0);
    endtask

    // Long output hold-off while the sender keeps offering: input must stall.
    task automatic test_output_backpressure();
        set_config(3'd4, 15'd7, 15'd5, 15'd300, 15'd3);
        hold_off_len = 2000;
        repeat (40) send_item(random_item());
        wait_results_drained();
    endtask

    // Sender stops mid-stream until every result is back, then resumes.
    task automatic test_sender_pause();
        random_config();
        repeat (15) send_item(random_item());
        wait_results_drained();
        repeat (15) send_item(random_item());
        wait_results_drained();
    endtask

    initial begin
        dims_cfg = 3'd1;
        for (int k = 0; k < NFIELD; k++) extent_cfg[k] = COORD_W'(1);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_dim_clamp();
        test_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();

        // catch anything emitted after the last expected result
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
